// ----- hw/rtl/arrpb_pkg.sv -----
package arrpb_pkg;

    // Default pixel coordinate width on the input channel.
    localparam int COORD_BITS_DEF = 12;

    // Largest corner radius honored after the clamp.
    localparam int MAX_RADIUS = 255;

    // Field widths fixed by the register map.
    localparam int POS_BITS    = 13;
    localparam int SIZE_BITS   = 12;
    localparam int R_BITS      = 8;
    localparam int COLOR_BITS  = 32;
    localparam int CFG_IDX_BITS = 3;

    // Corner offsets never exceed the radius plus one, so 9 bits hold them.
    localparam int Q_BITS    = R_BITS + 1;
    localparam int N_BITS    = 2 * Q_BITS;
    localparam int FRAC_BITS = 16;
    localparam int RAD_BITS  = N_BITS + FRAC_BITS;
    localparam int ROOT_BITS = RAD_BITS / 2;
    localparam int REM_BITS  = ROOT_BITS + 2;
    localparam int COV_BITS  = 9;

    localparam logic [CFG_IDX_BITS-1:0] REG_RECT_LEFT     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RECT_TOP      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RECT_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RECT_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_CORNER_RADIUS = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_FILL_COLOR    = 3'd5;

    // What a pixel needs once the geometry has been looked at.
    typedef enum logic [1:0] {
        KIND_SKIP,
        KIND_FILL,
        KIND_FULL,
        KIND_ARC
    } kind_t;

    typedef struct packed {
        logic signed [POS_BITS-1:0] rect_left;
        logic signed [POS_BITS-1:0] rect_top;
        logic [SIZE_BITS-1:0]       rect_width;
        logic [SIZE_BITS-1:0]       rect_height;
        logic [R_BITS-1:0]          corner_radius;
        logic [COLOR_BITS-1:0]      fill_color;
    } cfg_t;

    typedef struct packed {
        kind_t                  kind;
        logic [R_BITS-1:0]      radius;
        logic [COLOR_BITS-1:0]  dest;
    } side_t;

    typedef struct packed {
        logic [RAD_BITS-1:0]  rad;
        logic [ROOT_BITS-1:0] root;
        logic [REM_BITS-1:0]  rem;
        side_t                side;
    } root_beat_t;

endpackage

// ----- hw/rtl/arrpb_prep.sv -----
module arrpb_prep #(
    parameter int COORD_BITS = arrpb_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  arrpb_pkg::cfg_t                  cfg,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [COORD_BITS-1:0]            pixel_x,
    input  logic [COORD_BITS-1:0]            pixel_y,
    input  logic [arrpb_pkg::COLOR_BITS-1:0] dest_pixel,
    output logic                             out_valid,
    input  logic                             out_ready,
    output arrpb_pkg::root_beat_t            out_beat
);

    // Wide enough for pixel coordinates, signed edges and the grown box.
    localparam int CW = ((COORD_BITS > arrpb_pkg::POS_BITS) ?
                         COORD_BITS : arrpb_pkg::POS_BITS) + 3;
    localparam logic signed [CW-1:0] S_ONE = CW'(1);

    logic signed [CW-1:0]             px, py, xl, yt, xr, yb, rs;
    logic signed [CW-1:0]             qx_w, qy_w;
    logic [arrpb_pkg::R_BITS-1:0]     r_lim;
    logic                             in_box, grown;
    arrpb_pkg::kind_t                 kind_w;

    logic                             a_valid_reg, a_ready;
    arrpb_pkg::kind_t                 a_kind_reg;
    logic [arrpb_pkg::R_BITS-1:0]     a_radius_reg;
    logic [arrpb_pkg::COLOR_BITS-1:0] a_dest_reg;
    logic [arrpb_pkg::Q_BITS-1:0]     a_qx_reg, a_qy_reg;

    logic                             b_valid_reg, b_ready;
    logic [arrpb_pkg::N_BITS-1:0]     n_w;
    arrpb_pkg::root_beat_t            b_beat_reg;

    // Geometry stage: clamp the radius, test both boxes, find corner offsets.
    always_comb
    begin
        r_lim = cfg.corner_radius;
        if (32'(r_lim) > arrpb_pkg::MAX_RADIUS)
        begin
            r_lim = arrpb_pkg::R_BITS'(arrpb_pkg::MAX_RADIUS);
        end
        if (11'(r_lim) > cfg.rect_width[11:1])
        begin
            r_lim = arrpb_pkg::R_BITS'(cfg.rect_width[11:1]);
        end
        if (11'(r_lim) > cfg.rect_height[11:1])
        begin
            r_lim = arrpb_pkg::R_BITS'(cfg.rect_height[11:1]);
        end

        px = CW'(pixel_x);
        py = CW'(pixel_y);
        xl = CW'($signed(cfg.rect_left));
        yt = CW'($signed(cfg.rect_top));
        xr = xl + CW'(cfg.rect_width);
        yb = yt + CW'(cfg.rect_height);
        rs = CW'(r_lim);

        in_box = (px >= xl) && (px < xr) && (py >= yt) && (py < yb);
        grown  = (px >= xl - S_ONE) && (px < xr + S_ONE) &&
                 (py >= yt - S_ONE) && (py < yb + S_ONE);

        if (px < xl + rs)
        begin
            qx_w = xl + rs - px;
        end
        else if (px > xr - rs)
        begin
            qx_w = px - (xr - rs);
        end
        else
        begin
            qx_w = '0;
        end

        if (py < yt + rs)
        begin
            qy_w = yt + rs - py;
        end
        else if (py > yb - rs)
        begin
            qy_w = py - (yb - rs);
        end
        else
        begin
            qy_w = '0;
        end

        if (cfg.corner_radius == '0)
        begin
            kind_w = in_box ? arrpb_pkg::KIND_FILL : arrpb_pkg::KIND_SKIP;
        end
        else if ((cfg.fill_color[31:24] == 8'd0) || !grown)
        begin
            kind_w = arrpb_pkg::KIND_SKIP;
        end
        else if ((qx_w == '0) && (qy_w == '0))
        begin
            kind_w = arrpb_pkg::KIND_FULL;
        end
        else
        begin
            kind_w = arrpb_pkg::KIND_ARC;
        end
    end

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_kind_reg   <= kind_w;
            a_radius_reg <= r_lim;
            a_dest_reg   <= dest_pixel;
            a_qx_reg     <= qx_w[arrpb_pkg::Q_BITS-1:0];
            a_qy_reg     <= qy_w[arrpb_pkg::Q_BITS-1:0];
        end
    end

    // Squared distance to the arc center, placed as the root radicand n * 2^16.
    assign n_w = arrpb_pkg::N_BITS'(a_qx_reg) * arrpb_pkg::N_BITS'(a_qx_reg) +
                 arrpb_pkg::N_BITS'(a_qy_reg) * arrpb_pkg::N_BITS'(a_qy_reg);

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && b_ready)
        begin
            b_beat_reg.rad         <= {n_w, {arrpb_pkg::FRAC_BITS{1'b0}}};
            b_beat_reg.root        <= '0;
            b_beat_reg.rem         <= '0;
            b_beat_reg.side.kind   <= a_kind_reg;
            b_beat_reg.side.radius <= a_radius_reg;
            b_beat_reg.side.dest   <= a_dest_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_beat  = b_beat_reg;

endmodule

// ----- hw/rtl/arrpb_root_cell.sv -----
module arrpb_root_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  arrpb_pkg::root_beat_t in_beat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output arrpb_pkg::root_beat_t out_beat
);

    // One restoring square root step: two radicand bits in, one root bit out.
    logic [arrpb_pkg::REM_BITS+1:0] cur_w, trial_w, diff_w;
    logic                           take_w;
    arrpb_pkg::root_beat_t          beat_next, beat_reg;
    logic                           valid_reg;

    always_comb
    begin
        cur_w   = {in_beat.rem, in_beat.rad[arrpb_pkg::RAD_BITS-1 -: 2]};
        trial_w = (arrpb_pkg::REM_BITS + 2)'({in_beat.root, 2'b01});
        diff_w  = cur_w - trial_w;
        take_w  = (cur_w >= trial_w);

        beat_next      = in_beat;
        beat_next.rad  = in_beat.rad << 2;
        beat_next.root = {in_beat.root[arrpb_pkg::ROOT_BITS-2:0], take_w};
        beat_next.rem  = take_w ? diff_w[arrpb_pkg::REM_BITS-1:0]
                                : cur_w[arrpb_pkg::REM_BITS-1:0];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// ----- hw/rtl/arrpb_blend.sv -----
module arrpb_blend (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [arrpb_pkg::COLOR_BITS-1:0] fill_color,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  arrpb_pkg::root_beat_t            in_beat,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             write_enable,
    output logic [arrpb_pkg::COLOR_BITS-1:0] pixel_out
);

    localparam int CV_BITS = arrpb_pkg::ROOT_BITS + 2;

    logic signed [CV_BITS-1:0]         cs_w;
    logic [arrpb_pkg::COV_BITS-1:0]    cov_w;
    logic [16:0]                       prod_w;
    logic                              we_w;

    logic                              c_valid_reg, c_ready;
    logic                              c_we_reg, c_fill_reg;
    logic [7:0]                        c_alpha_reg;
    logic [arrpb_pkg::COLOR_BITS-1:0]  c_dest_reg;

    logic                              d_valid_reg, d_ready;
    logic                              d_we_reg;
    logic [arrpb_pkg::COLOR_BITS-1:0]  d_pixel_reg;
    logic [arrpb_pkg::COLOR_BITS-1:0]  pixel_w;
    logic [7:0]                        ia_w;

    function automatic logic [7:0] blend_ch(input logic [7:0] s, input logic [7:0] d,
                                            input logic [7:0] a, input logic [7:0] ia);
        logic [15:0] acc;
        acc = 16'(s) * 16'(a) + 16'(d) * 16'(ia);
        return acc[15:8];
    endfunction

    // Coverage is the radius plus one half, less the distance, held to 0..256.
    always_comb
    begin
        cs_w = $signed(CV_BITS'({in_beat.side.radius, 8'h80})) -
               $signed(CV_BITS'(in_beat.root));
        if (in_beat.side.kind == arrpb_pkg::KIND_FULL)
        begin
            cov_w = 9'd256;
        end
        else if (cs_w[CV_BITS-1])
        begin
            cov_w = '0;
        end
        else if (cs_w > CV_BITS'(256))
        begin
            cov_w = 9'd256;
        end
        else
        begin
            cov_w = cs_w[arrpb_pkg::COV_BITS-1:0];
        end
        prod_w = 17'(fill_color[31:24]) * 17'(cov_w);

        case (in_beat.side.kind)
            arrpb_pkg::KIND_FILL: we_w = 1'b1;
            arrpb_pkg::KIND_FULL: we_w = 1'b1;
            arrpb_pkg::KIND_ARC:  we_w = (cov_w != '0);
            default:              we_w = 1'b0;
        endcase
    end

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign in_ready = c_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_ready)
            begin
                c_valid_reg <= in_valid;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && c_ready)
        begin
            c_we_reg    <= we_w;
            c_fill_reg  <= (in_beat.side.kind == arrpb_pkg::KIND_FILL);
            c_alpha_reg <= prod_w[15:8];
            c_dest_reg  <= in_beat.side.dest;
        end
    end

    // Final pixel: zero when not written, else plain fill, opaque source, untouched destination or a mix.
    always_comb
    begin
        ia_w = 8'd255 - c_alpha_reg;
        if (!c_we_reg)
        begin
            pixel_w = '0;
        end
        else if (c_fill_reg)
        begin
            pixel_w = fill_color;
        end
        else if (c_alpha_reg == 8'hFF)
        begin
            pixel_w = {8'hFF, fill_color[23:0]};
        end
        else if (c_alpha_reg == 8'h00)
        begin
            pixel_w = c_dest_reg;
        end
        else
        begin
            pixel_w = {8'hFF,
                       blend_ch(fill_color[23:16], c_dest_reg[23:16], c_alpha_reg, ia_w),
                       blend_ch(fill_color[15:8],  c_dest_reg[15:8],  c_alpha_reg, ia_w),
                       blend_ch(fill_color[7:0],   c_dest_reg[7:0],   c_alpha_reg, ia_w)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_valid_reg && d_ready)
        begin
            d_we_reg    <= c_we_reg;
            d_pixel_reg <= pixel_w;
        end
    end

    assign out_valid    = d_valid_reg;
    assign write_enable = d_we_reg;
    assign pixel_out    = d_pixel_reg;

endmodule

// ----- hw/rtl/aa_rounded_rect_pixel_blend_unit.sv -----
// Channel   Handshake                Payload
// in        in_valid / in_ready      pixel_x, pixel_y, dest_pixel
// out       out_valid / out_ready    write_enable, pixel_out
// cfg       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One pixel beat is taken every clock while the output is not stalled; each beat
// passes two geometry stages, seventeen square root cells and two blend stages.
// Each root cell is its own pipeline stage and yields one root bit.
// Reset clears every stage valid bit and all six registers to zero.
// A stalled output holds its beat; upstream stages keep filling any empty slot
// behind it, so input ready drops only once every stage holds a beat.
module aa_rounded_rect_pixel_blend_unit #(
    parameter int COORD_BITS = arrpb_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [COORD_BITS-1:0]              pixel_x,
    input  logic [COORD_BITS-1:0]              pixel_y,
    input  logic [arrpb_pkg::COLOR_BITS-1:0]   dest_pixel,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               write_enable,
    output logic [arrpb_pkg::COLOR_BITS-1:0]   pixel_out,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [arrpb_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [arrpb_pkg::COLOR_BITS-1:0]   cfg_data
);

    localparam int NCELL = arrpb_pkg::ROOT_BITS;

    logic signed [arrpb_pkg::POS_BITS-1:0] rect_left_reg, rect_top_reg;
    logic [arrpb_pkg::SIZE_BITS-1:0]       rect_width_reg, rect_height_reg;
    logic [arrpb_pkg::R_BITS-1:0]          corner_radius_reg;
    logic [arrpb_pkg::COLOR_BITS-1:0]      fill_color_reg;
    arrpb_pkg::cfg_t                       cfg;

    // Position k of the chain is the beat entering root cell k; the last one
    // feeds the blend stages.
    logic [NCELL:0]                        chain_valid, chain_ready;
    arrpb_pkg::root_beat_t                 chain_beat [NCELL+1];

    // Registers are written whenever a beat arrives; the host must write them only
    // while no pixel is in flight, which the block itself does not enforce.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_left_reg     <= '0;
            rect_top_reg      <= '0;
            rect_width_reg    <= '0;
            rect_height_reg   <= '0;
            corner_radius_reg <= '0;
            fill_color_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                arrpb_pkg::REG_RECT_LEFT:
                    rect_left_reg <= cfg_data[arrpb_pkg::POS_BITS-1:0];
                arrpb_pkg::REG_RECT_TOP:
                    rect_top_reg <= cfg_data[arrpb_pkg::POS_BITS-1:0];
                arrpb_pkg::REG_RECT_WIDTH:
                    rect_width_reg <= cfg_data[arrpb_pkg::SIZE_BITS-1:0];
                arrpb_pkg::REG_RECT_HEIGHT:
                    rect_height_reg <= cfg_data[arrpb_pkg::SIZE_BITS-1:0];
                arrpb_pkg::REG_CORNER_RADIUS:
                    corner_radius_reg <= cfg_data[arrpb_pkg::R_BITS-1:0];
                arrpb_pkg::REG_FILL_COLOR:
                    fill_color_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.rect_left     = rect_left_reg;
    assign cfg.rect_top      = rect_top_reg;
    assign cfg.rect_width    = rect_width_reg;
    assign cfg.rect_height   = rect_height_reg;
    assign cfg.corner_radius = corner_radius_reg;
    assign cfg.fill_color    = fill_color_reg;

    // Geometry: radius clamp, box tests and the squared corner distance.
    arrpb_prep #(
        .COORD_BITS (COORD_BITS)
    ) u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .dest_pixel (dest_pixel),
        .out_valid  (chain_valid[0]),
        .out_ready  (chain_ready[0]),
        .out_beat   (chain_beat[0])
    );

    // The square root of n * 2^16 is built one bit per cell, most significant
    // bit first, with the pixel's side data riding along in each beat.
    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        arrpb_root_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_beat   (chain_beat[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_beat  (chain_beat[k+1])
        );
    end

    // Coverage, effective alpha and the per-channel mix over the destination.
    arrpb_blend u_blend (
        .clk          (clk),
        .rst_n        (rst_n),
        .fill_color   (fill_color_reg),
        .in_valid     (chain_valid[NCELL]),
        .in_ready     (chain_ready[NCELL]),
        .in_beat      (chain_beat[NCELL]),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .write_enable (write_enable),
        .pixel_out    (pixel_out)
    );

    // A pixel that is not written always carries an all-zero value.
    a_zero_when_idle : assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !write_enable) |-> (pixel_out == '0))
        else $error("unwritten pixel carries a nonzero value");

    // With the output slot empty, every stage behind it has room.
    a_ready_chain : assert property (
        @(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while the output slot is empty");

    // A finished root leaves a remainder of at most twice the root.
    a_root_floor : assert property (
        @(posedge clk) disable iff (!rst_n)
        chain_valid[NCELL] |->
            (chain_beat[NCELL].rem <=
             arrpb_pkg::REM_BITS'({chain_beat[NCELL].root, 1'b0})))
        else $error("square root remainder out of range");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

// Testbench for the antialiased rounded rectangle pixel shader.
//
// A driver always block feeds pixel beats from a queue of pending requests that
// the stimulus initial block fills. At each accepted input beat the driver runs
// a behavioral shader on the beat and appends the predicted write flag and pixel
// to a queue of expected results. A monitor always block takes output beats
// under random backpressure and checks each one against the oldest prediction.
// Register writes go over the configuration channel and only while the
// pipeline is empty, so every prediction uses the setup the hardware used.
module tb;

    localparam int        COORD_W    = 12;
    localparam int        COORD_MAX  = (1 << COORD_W) - 1;
    // Idle margin beyond the block's pipeline depth, with some extra room.
    localparam int        PIPE_SLACK = 30;
    localparam int        RAND_SETUPS    = 8;
    localparam int        ITEMS_PER_SETUP = 250;

    localparam logic [31:0] RB_MASK    = 32'h00FF00FF;
    localparam logic [31:0] G_MASK     = 32'h0000FF00;
    localparam logic [31:0] ALPHA_MASK = 32'hFF000000;
    localparam logic [31:0] RGB_MASK   = 32'h00FFFFFF;
    localparam int          COV_FULL   = 256;
    localparam int          COV_HALF   = 128;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [31:0]        dest;
    } pixel_req_t;

    typedef struct packed {
        logic        we;
        logic [31:0] pix;
    } shaded_pixel_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                               in_valid   = 1'b0;
    logic                               in_ready;
    logic [COORD_W-1:0]                 pixel_x    = '0;
    logic [COORD_W-1:0]                 pixel_y    = '0;
    logic [arrpb_pkg::COLOR_BITS-1:0]   dest_pixel = '0;

    logic                               out_valid;
    logic                               out_ready  = 1'b0;
    logic                               write_enable;
    logic [arrpb_pkg::COLOR_BITS-1:0]   pixel_out;

    logic                               cfg_valid  = 1'b0;
    logic                               cfg_ready;
    logic [arrpb_pkg::CFG_IDX_BITS-1:0] cfg_index  = '0;
    logic [arrpb_pkg::COLOR_BITS-1:0]   cfg_data   = '0;

    // Shadow copy of the register file, as the hardware holds it.
    arrpb_pkg::cfg_t shape = '0;

    pixel_req_t    pending_pixels[$];
    shaded_pixel_t expected_pixels[$];

    // When set, neither side of the pipeline inserts idle cycles.
    bit no_idle = 1'b0;

    int error_count   = 0;
    int checked_count = 0;
    int written_count = 0;
    int setup_count   = 0;
    int send_gap      = 0;
    int stall_left    = 0;

    aa_rounded_rect_pixel_blend_unit #(
        .COORD_BITS(COORD_W)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .dest_pixel   (dest_pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .write_enable (write_enable),
        .pixel_out    (pixel_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mostly back to back, sometimes a short gap, rarely a long one.
    function automatic int next_gap();
        int roll;
        if (no_idle)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 70)
        begin
            return 0;
        end
        else if (roll < 92)
        begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(8, 30);
    endfunction

    // Corner radius after the clamp to the limit and to half of each side.
    function automatic int clamped_radius(arrpb_pkg::cfg_t c);
        int r;
        r = int'(c.corner_radius);
        if (r > arrpb_pkg::MAX_RADIUS)
        begin
            r = arrpb_pkg::MAX_RADIUS;
        end
        if (r > int'(c.rect_width) / 2)
        begin
            r = int'(c.rect_width) / 2;
        end
        if (r > int'(c.rect_height) / 2)
        begin
            r = int'(c.rect_height) / 2;
        end
        return r;
    endfunction

    // Source-over blend of a premultiplied-free ARGB source onto the destination.
    function automatic logic [31:0] blend_over(logic [31:0] dst, logic [31:0] src);
        logic [63:0] a;
        logic [63:0] ia;
        logic [63:0] rb;
        logic [63:0] g;
        a = {56'd0, src[31:24]};
        if (a == 64'd255)
        begin
            return src;
        end
        if (a == 64'd0)
        begin
            return dst;
        end
        ia = 64'd255 - a;
        rb = (({32'd0, src & RB_MASK} * a + {32'd0, dst & RB_MASK} * ia) >> 8)
             & {32'd0, RB_MASK};
        g  = (({32'd0, src & G_MASK} * a + {32'd0, dst & G_MASK} * ia) >> 8)
             & {32'd0, G_MASK};
        return ALPHA_MASK | rb[31:0] | g[31:0];
    endfunction

    // What the shader must produce for one pixel under the current setup.
    function automatic shaded_pixel_t shade_pixel(logic [COORD_W-1:0] px_in,
                                                  logic [COORD_W-1:0] py_in,
                                                  logic [31:0] dst);
        shaded_pixel_t res;
        int px, py, lx, ty, w, h, r, qx, qy, cov;
        longint unsigned target, root, step_bit, trial;
        longint c;
        int unsigned src_a, a;
        res = '0;
        px = int'(px_in);
        py = int'(py_in);
        lx = {{19{shape.rect_left[arrpb_pkg::POS_BITS-1]}}, shape.rect_left};
        ty = {{19{shape.rect_top[arrpb_pkg::POS_BITS-1]}}, shape.rect_top};
        w  = int'(shape.rect_width);
        h  = int'(shape.rect_height);
        src_a = 32'(shape.fill_color[31:24]);

        // A zero radius is a hard-edged opaque overwrite of the rectangle.
        if (shape.corner_radius == '0)
        begin
            if (px >= lx && px < lx + w && py >= ty && py < ty + h)
            begin
                res.we  = 1'b1;
                res.pix = shape.fill_color;
            end
            return res;
        end

        r = clamped_radius(shape);
        if (src_a == 0)
        begin
            return res;
        end
        // Only the box grown by one pixel on every side can get coverage.
        if (px < lx - 1 || px >= lx + w + 1 || py < ty - 1 || py >= ty + h + 1)
        begin
            return res;
        end

        qx = (px < lx + r) ? (lx + r - px) : (px > lx + w - r) ? (px - (lx + w - r)) : 0;
        qy = (py < ty + r) ? (ty + r - py) : (py > ty + h - r) ? (py - (ty + h - r)) : 0;

        if (qx <= 0 && qy <= 0)
        begin
            cov = COV_FULL;
        end
        else
        begin
            // Exact floor of the square root of the squared distance scaled by 2^16: the distance with 8 fraction bits.
            target   = longint'(qx * qx + qy * qy) << 16;
            root     = 0;
            step_bit = 64'd1 << 24;
            while (step_bit != 0)
            begin
                trial = root | step_bit;
                if (trial * trial <= target)
                begin
                    root = trial;
                end
                step_bit = step_bit >> 1;
            end
            c = longint'(r) * 256 + COV_HALF - longint'(root);
            if (c < 0)
            begin
                c = 0;
            end
            if (c > COV_FULL)
            begin
                c = COV_FULL;
            end
            cov = int'(c);
        end
        if (cov == 0)
        begin
            return res;
        end

        a = (src_a * cov) >> 8;
        res.we  = 1'b1;
        res.pix = blend_over(dst, {a[7:0], 24'd0} | (shape.fill_color & RGB_MASK));
        return res;
    endfunction

    // Driver: presents pending pixels, holds a beat until it is taken, and
    // records the prediction for each beat at the edge that accepts it.
    always @(posedge clk or negedge rst_n)
    begin
        pixel_req_t req;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_pixels.push_back(shade_pixel(pixel_x, pixel_y, dest_pixel));
            end
            if (in_valid && !in_ready)
            begin
                // Beat still waiting: keep valid and payload as they are.
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_pixels.size() != 0)
            begin
                req = pending_pixels.pop_front();
                pixel_x    <= req.x;
                pixel_y    <= req.y;
                dest_pixel <= req.dest;
                in_valid   <= 1'b1;
                send_gap = next_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: random backpressure on the output, and the check of every beat.
    always @(posedge clk or negedge rst_n)
    begin
        shaded_pixel_t exp_pix;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: output beat with nothing expected: we=%0b pixel=%h",
                             $time, write_enable, pixel_out);
                    error_count++;
                end
                else
                begin
                    exp_pix = expected_pixels.pop_front();
                    checked_count++;
                    if (exp_pix.we)
                    begin
                        written_count++;
                    end
                    if (write_enable !== exp_pix.we)
                    begin
                        $display("%0t: write_enable mismatch: expected %0b, got %0b",
                                 $time, exp_pix.we, write_enable);
                        error_count++;
                    end
                    if (pixel_out !== exp_pix.pix)
                    begin
                        $display("%0t: pixel_out mismatch: expected %h, got %h",
                                 $time, exp_pix.pix, pixel_out);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                stall_left = next_gap();
            end
        end
    end

    // One beat on the configuration channel; the shadow copy follows on accept.
    task automatic write_reg(logic [arrpb_pkg::CFG_IDX_BITS-1:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            arrpb_pkg::REG_RECT_LEFT:
                shape.rect_left = data[arrpb_pkg::POS_BITS-1:0];
            arrpb_pkg::REG_RECT_TOP:
                shape.rect_top = data[arrpb_pkg::POS_BITS-1:0];
            arrpb_pkg::REG_RECT_WIDTH:
                shape.rect_width = data[arrpb_pkg::SIZE_BITS-1:0];
            arrpb_pkg::REG_RECT_HEIGHT:
                shape.rect_height = data[arrpb_pkg::SIZE_BITS-1:0];
            arrpb_pkg::REG_CORNER_RADIUS:
                shape.corner_radius = data[arrpb_pkg::R_BITS-1:0];
            arrpb_pkg::REG_FILL_COLOR:
                shape.fill_color = data;
            default: ;
        endcase
    endtask

    task automatic apply_setup(int left, int top, int w, int h, int r, logic [31:0] color);
        write_reg(arrpb_pkg::REG_RECT_LEFT,     left);
        write_reg(arrpb_pkg::REG_RECT_TOP,      top);
        write_reg(arrpb_pkg::REG_RECT_WIDTH,    w);
        write_reg(arrpb_pkg::REG_RECT_HEIGHT,   h);
        write_reg(arrpb_pkg::REG_CORNER_RADIUS, r);
        write_reg(arrpb_pkg::REG_FILL_COLOR,    color);
        setup_count++;
    endtask

    // Waits until the pipeline has drained and then a little longer.
    task automatic wait_idle();
        while (pending_pixels.size() != 0 || expected_pixels.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    task automatic queue_pixel(int x, int y, logic [31:0] dest);
        pixel_req_t req;
        req.x    = COORD_W'(x);
        req.y    = COORD_W'(y);
        req.dest = dest;
        pending_pixels.push_back(req);
    endtask

    function automatic int to_coord(int v);
        if (v < 0)
        begin
            return 0;
        end
        if (v > COORD_MAX)
        begin
            return COORD_MAX;
        end
        return v;
    endfunction

    // One coordinate on an axis, biased toward the arcs and the box edges.
    function automatic int pick_axis(int lo, int len, int r);
        case ($urandom_range(0, 3))
            0:       return lo - 2 + int'($urandom_range(0, r + 3));
            1:       return lo + len - r - 2 + int'($urandom_range(0, r + 4));
            default: return lo - 3 + int'($urandom_range(0, len + 5));
        endcase
    endfunction

    task automatic queue_random_pixel();
        int lx, ty, r, x, y;
        logic [31:0] dest;
        lx = {{19{shape.rect_left[arrpb_pkg::POS_BITS-1]}}, shape.rect_left};
        ty = {{19{shape.rect_top[arrpb_pkg::POS_BITS-1]}}, shape.rect_top};
        r  = clamped_radius(shape);
        if ($urandom_range(0, 9) < 2)
        begin
            x = $urandom_range(0, COORD_MAX);
            y = $urandom_range(0, COORD_MAX);
        end
        else
        begin
            x = to_coord(pick_axis(lx, int'(shape.rect_width), r));
            y = to_coord(pick_axis(ty, int'(shape.rect_height), r));
        end
        case ($urandom_range(0, 15))
            0:       dest = 32'h0000_0000;
            1:       dest = 32'hFFFF_FFFF;
            default: dest = $urandom;
        endcase
        queue_pixel(x, y, dest);
    endtask

    // A random setup: mostly over the surface with modest sizes, sometimes the
    // full coordinate range, the largest sizes, or a radius of zero.
    task automatic random_setup();
        int left, top, w, h, r;
        logic [31:0] color;
        left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 8191)) - 4096
                                           : int'($urandom_range(0, 4200)) - 100;
        top  = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 8191)) - 4096
                                           : int'($urandom_range(0, 4200)) - 100;
        case ($urandom_range(0, 9))
            0:       w = 4095;
            1:       w = $urandom_range(0, 4095);
            2, 3:    w = $urandom_range(41, 600);
            default: w = $urandom_range(0, 40);
        endcase
        case ($urandom_range(0, 9))
            0:       h = 4095;
            1:       h = $urandom_range(0, 4095);
            2, 3:    h = $urandom_range(41, 600);
            default: h = $urandom_range(0, 40);
        endcase
        case ($urandom_range(0, 5))
            0:       r = 0;
            1:       r = 255;
            2, 3:    r = $urandom_range(1, 20);
            default: r = $urandom_range(1, 255);
        endcase
        color = $urandom;
        case ($urandom_range(0, 5))
            0: color[31:24] = 8'h00;
            1: color[31:24] = 8'hFF;
            2: color[31:24] = 8'($urandom_range(1, 8));
            default: ;
        endcase
        apply_setup(left, top, w, h, r, color);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at their reset values: zero-sized plain fill, nothing written.
        queue_pixel(0, 0, 32'h0000_0000);
        queue_pixel(COORD_MAX, COORD_MAX, 32'hFFFF_FFFF);
        wait_idle();

        // Plain opaque fill, probing the left, right and top edges from both sides and the bottom edge from inside.
        apply_setup(10, 20, 100, 60, 0, 32'h8012_3456);
        queue_pixel(10, 20, 32'h1111_1111);
        queue_pixel(109, 79, 32'h2222_2222);
        queue_pixel(110, 79, 32'h3333_3333);
        queue_pixel(9, 20, 32'h4444_4444);
        queue_pixel(50, 19, 32'h5555_5555);
        wait_idle();

        // Largest position and size with the largest radius, near the far corner.
        apply_setup(4095, 4095, 4095, 4095, 255, 32'hFFFF_FFFF);
        queue_pixel(4094, 4094, 32'hA5A5_A5A5);
        queue_pixel(COORD_MAX, COORD_MAX, 32'h5A5A_5A5A);
        wait_idle();

        // Most negative position: the rectangle ends just left of the surface.
        apply_setup(-4096, -4096, 4095, 4095, 255, 32'hFF00_FF00);
        queue_pixel(0, 0, 32'h0123_4567);
        queue_pixel(COORD_MAX, 0, 32'h89AB_CDEF);
        wait_idle();

        // Requested radius far above half the width: clamped to five.
        apply_setup(100, 100, 10, 30, 200, 32'hC0FF_8040);
        queue_pixel(100, 100, 32'h0000_0000);
        queue_pixel(99, 99, 32'hFFFF_FFFF);
        queue_pixel(105, 115, 32'h1234_5678);
        queue_pixel(110, 115, 32'h8765_4321);
        queue_pixel(104, 99, 32'hDEAD_BEEF);
        wait_idle();

        // Radius clamped all the way to zero on a one-pixel box, still antialiased.
        apply_setup(0, 0, 1, 1, 9, 32'hFF00_00FF);
        queue_pixel(0, 0, 32'h1357_9BDF);
        queue_pixel(1, 1, 32'h2468_ACE0);
        queue_pixel(2, 2, 32'hFFFF_FFFF);
        wait_idle();

        // Fully transparent fill color with a radius: never writes.
        apply_setup(0, 0, 50, 50, 4, 32'h00AB_CDEF);
        queue_pixel(10, 10, 32'h7777_7777);
        queue_pixel(0, 0, 32'h8888_8888);
        wait_idle();

        // Near-transparent fill: faint blend inside, alpha rounding to zero on the arc.
        apply_setup(20, 20, 40, 40, 16, 32'h01FF_FFFF);
        queue_pixel(25, 30, 32'h0000_0000);
        queue_pixel(20, 20, 32'h4242_4242);
        queue_pixel(30, 30, 32'h8080_8080);
        wait_idle();

        // Random setups with random pixels. Every third setup runs with no idle
        // cycles on either side; every other one has the sender stop halfway
        // until all results are back.
        for (int s = 0; s < RAND_SETUPS; s++)
        begin
            random_setup();
            no_idle = (s % 3 == 1);
            for (int i = 0; i < ITEMS_PER_SETUP; i++)
            begin
                if (s % 2 == 0 && i == ITEMS_PER_SETUP / 2)
                begin
                    wait_idle();
                end
                queue_random_pixel();
            end
            wait_idle();
        end
        no_idle = 1'b0;

        wait_idle();
        $display("tb: %0d pixels checked across %0d register setups, %0d of them written",
                 checked_count, setup_count, written_count);
        $display("tb: %0d mismatches", error_count);
        if (error_count == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("tb: timeout with %0d results still expected", expected_pixels.size());
        $display("tb: FAIL");
        $finish;
    end

endmodule
